FILE: rtl/core/ukd_pkg.sv
// Shared types, widths and codes for the unique-key deque.
// No dependencies; imported by the top level and the checker.
package ukd_pkg;

    // Store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W       = 3;
    localparam int KEY_W      = 31;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_O_W  = 5;
    localparam int ENTRY_W    = KEY_W + HANDLE_W;

    localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_DUP      = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_POP_CAP,
        S_FIN
    } t_state;

    // Ring slot of (base + off) mod DEPTH; both operands are below DEPTH
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/ukd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ukd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/unique_key_deque_top.sv
// Unique-key deque: bounded ring of (key, handle) entries with key lookup.
// Depends on ukd_pkg and ukd_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: an op code,
//   a key and a handle. Output channel (o_out_valid / i_out_ready) returns
//   exactly one result per request: status, handle and entry count after it.
//   Push front/back refuses a key already held (duplicate) or a full store;
//   pop front/back returns the removed handle or reports empty; search gives
//   the handle of the first matching entry from the front, or not found.
// Timing:
//   A push or search scans the held entries through the read port of the
//   entry RAM, one slot per cycle, and stops at a match or after the last
//   held entry. A pop reads the removed entry (no read when empty); an unused
//   op code goes straight to the result. o_in_ready is high only while idle,
//   which the block reenters as the result is loaded.
// Reset: synchronous, active low; the store comes up empty and ready at once.
//   RAM contents are not cleared: only data from slots holding entries is ever used.
// Stall: a result waits in the output register while the next request is
//   taken and processed; its final step holds until the register is free.
module unique_key_deque_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ukd_pkg::OP_W-1:0]      i_op,
    input  logic [ukd_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [ukd_pkg::HANDLE_W-1:0]  i_entry_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ukd_pkg::STATUS_W-1:0]  o_status,
    output logic [ukd_pkg::HANDLE_W-1:0]  o_result_handle,
    output logic [ukd_pkg::COUNT_O_W-1:0] o_entry_count
);

    import ukd_pkg::*;

    // control state
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    logic             r_found;
    logic             r_out_valid;

    // request and result payload
    t_op                   r_op;
    logic [KEY_W-1:0]      r_key;
    logic [HANDLE_W-1:0]   r_hnd_in;
    logic [HANDLE_W-1:0]   r_res_hnd;
    t_status               r_out_status;
    logic [HANDLE_W-1:0]   r_out_hnd;
    logic [COUNT_O_W-1:0]  r_out_count;

    // RAM port signals
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [IDX_W-1:0]      w_raddr;
    logic [ENTRY_W-1:0]    w_rdata;
    logic [KEY_W-1:0]      w_rd_key;
    logic [HANDLE_W-1:0]   w_rd_hnd;

    // sequencer decode
    logic                  w_accept;
    logic                  w_hit;
    logic                  w_scan_done;
    logic                  w_issue;
    logic                  w_out_free;
    logic                  w_fin;
    t_status               w_fin_status;
    logic [HANDLE_W-1:0]   w_fin_hnd;
    logic [CNT_W-1:0]      n_count;
    logic [IDX_W-1:0]      n_front;
    logic                  w_push_ok;
    logic [CNT_W-1:0]      w_cnt_m1;
    logic [31:0]           w_cnt_ext;
    logic [IDX_W-1:0]      w_front_m1;

    assign w_rd_key   = w_rdata[ENTRY_W-1:HANDLE_W];
    assign w_rd_hnd   = w_rdata[HANDLE_W-1:0];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_front_m1 = (r_front == '0) ? IDX_W'(DEPTH - 1) : (r_front - IDX_W'(1));

    // scan: compare the entry read last cycle, issue the next slot
    assign w_hit       = r_pend && (w_rd_key == r_key);
    assign w_scan_done = w_hit || (r_idx == r_count);
    assign w_issue     = (r_state == S_SCAN) && !w_scan_done;
    assign w_fin       = (r_state == S_FIN) && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_op))
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_SEARCH: n_state = S_SCAN;
                        OP_POP_FRONT, OP_POP_BACK:
                            n_state = (r_count == '0) ? S_FIN : S_POP_RD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN:    if (w_scan_done) n_state = S_FIN;
            S_POP_RD:  n_state = S_POP_CAP;
            S_POP_CAP: n_state = S_FIN;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: ready, RAM read and write addresses, final result and next ring state
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        w_raddr      = slot_add(r_front, r_idx[IDX_W-1:0]);
        if (r_state == S_POP_RD) begin
            w_raddr = (r_op == OP_POP_FRONT) ? r_front
                                             : slot_add(r_front, w_cnt_m1[IDX_W-1:0]);
        end
        w_fin_status = STS_OK;
        w_fin_hnd    = '0;
        n_count      = r_count;
        n_front      = r_front;
        w_push_ok    = 1'b0;
        w_waddr      = slot_add(r_front, r_count[IDX_W-1:0]);
        unique case (r_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (r_found) begin
                    w_fin_status = STS_DUP;
                end else if (r_count == DEPTH_C) begin
                    w_fin_status = STS_FULL;
                end else begin
                    w_push_ok = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    if (r_op == OP_PUSH_FRONT) begin
                        n_front = w_front_m1;
                        w_waddr = w_front_m1;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (r_count == '0) begin
                    w_fin_status = STS_EMPTY;
                end else begin
                    w_fin_hnd = r_res_hnd;
                    n_count   = w_cnt_m1;
                    if (r_op == OP_POP_FRONT) begin
                        n_front = slot_add(r_front, IDX_W'(1));
                    end
                end
            end
            OP_SEARCH: begin
                if (r_found) begin
                    w_fin_hnd = r_res_hnd;
                end else begin
                    w_fin_status = STS_NOTFOUND;
                end
            end
            default: ;
        endcase
        w_we      = w_fin && w_push_ok;
        w_cnt_ext = 32'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= w_issue;
                if (w_issue) r_idx <= r_idx + CNT_W'(1);
                if (w_hit) r_found <= 1'b1;
            end
            if (w_fin) begin
                r_front     <= n_front;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= t_op'(i_op);
            r_key     <= i_entry_key;
            r_hnd_in  <= i_entry_handle;
            r_res_hnd <= '0;
        end else if ((r_state == S_SCAN && w_hit) || r_state == S_POP_CAP) begin
            r_res_hnd <= w_rd_hnd;
        end
        if (w_fin) begin
            r_out_status <= w_fin_status;
            r_out_hnd    <= w_fin_hnd;
            r_out_count  <= w_cnt_ext[COUNT_O_W-1:0];
        end
    end

    // entry store: {key, handle} per ring slot
    ukd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_key, r_hnd_in}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_handle = r_out_hnd;
    assign o_entry_count   = r_out_count;

endmodule

FILE: rtl/core/ukd_chk.sv
// Port-level checker for the unique-key deque, with its bind to the top level.
// Depends on ukd_pkg.
module ukd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [ukd_pkg::STATUS_W-1:0]  o_status,
    input logic [ukd_pkg::COUNT_O_W-1:0] o_entry_count
);

    import ukd_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // one request in work at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another was in work");

    // entry count never beyond the store depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_entry_count) <= 32'(DEPTH))
        else $error("entry count beyond depth");

    // a full report only when the store is at depth
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_FULL) |-> 32'(o_entry_count) == 32'(DEPTH))
        else $error("full status with free slots");

    // an empty report only with no entries held
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_EMPTY) |-> o_entry_count == '0)
        else $error("empty status with entries held");

endmodule

bind unique_key_deque_top ukd_chk u_ukd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
